// ===== src/eqps_pkg.sv =====
// Shared constants and types for the equality-pattern byte search block.
package eqps_pkg;

   localparam int MAX_PATTERN   = 16;
   localparam int OFFSET_WIDTH  = 32;
   localparam int LEN_WIDTH     = 5;
   localparam int CSR_IDX_WIDTH = 2;
   localparam int CSR_WIDTH     = 64;
   localparam int POS_WIDTH     = $clog2(MAX_PATTERN);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PATTERN_LENGTH = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PATTERN_LOW    = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PATTERN_HIGH   = 2'd2;

   localparam logic [LEN_WIDTH-1:0] PATTERN_LENGTH_RESET = 5'd2;
   localparam logic [LEN_WIDTH-1:0] MIN_PATTERN          = 5'd2;
   localparam logic [LEN_WIDTH-1:0] MAX_PATTERN_LEN      = LEN_WIDTH'(MAX_PATTERN);

   // Window of the latest bytes; element MAX_PATTERN-1 is the newest.
   typedef logic [MAX_PATTERN-1:0][7:0] window_type;

   // Result of testing one window.
   typedef struct packed {
      logic                    hit;
      logic [OFFSET_WIDTH-1:0] offset;
   } match_type;

endpackage

// ===== src/eqps_window.sv =====
// Sliding byte window and saturating stream byte counter.
module eqps_window (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [7:0]                    data_byte,
   input  logic                          restart,
   output eqps_pkg::window_type          window,
   output logic [eqps_pkg::OFFSET_WIDTH-1:0] bytes_seen
);
   import eqps_pkg::*;

   window_type              window_ff, window_in;
   logic [OFFSET_WIDTH-1:0] count_ff, count_in;

   // Shift in the new byte; a restart clears older bytes and the count first.
   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      if (accept) begin
         if (restart) begin
            window_in                = '0;
            window_in[MAX_PATTERN-1] = data_byte;
            count_in                 = OFFSET_WIDTH'(1);
         end else begin
            for (int i = 0; i < MAX_PATTERN - 1; i++) begin
               window_in[i] = window_ff[i+1];
            end
            window_in[MAX_PATTERN-1] = data_byte;
            if (count_ff != '1) begin
               count_in = count_ff + OFFSET_WIDTH'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         count_ff  <= '0;
      end else begin
         window_ff <= window_in;
         count_ff  <= count_in;
      end
   end

   assign window     = window_ff;
   assign bytes_seen = count_ff;

endmodule

// ===== src/eqps_match.sv =====
// Pairwise equality comparison of the window against the configured pattern.
module eqps_match (
   input  logic [eqps_pkg::LEN_WIDTH-1:0]    pattern_length,
   input  logic [eqps_pkg::CSR_WIDTH-1:0]    pattern_bytes_low,
   input  logic [eqps_pkg::CSR_WIDTH-1:0]    pattern_bytes_high,
   input  eqps_pkg::window_type              window,
   input  logic [eqps_pkg::OFFSET_WIDTH-1:0] bytes_seen,
   output eqps_pkg::match_type               result
);
   import eqps_pkg::*;

   logic [LEN_WIDTH-1:0]          len_eff;
   logic [LEN_WIDTH-1:0]          base;
   logic [2*CSR_WIDTH-1:0]        pattern_all;
   window_type                    pattern_aligned;
   logic [MAX_PATTERN-1:0]        active;
   logic                          mismatch;
   logic                          window_full;
   logic [LEN_WIDTH-1:0]          pos_diff;

   // Lengths above the maximum act as the maximum.
   always_comb begin
      len_eff = (pattern_length > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : pattern_length;
      base    = MAX_PATTERN_LEN - len_eff;
   end

   // Align pattern byte 0 with the window position of the oldest byte in use.
   always_comb begin
      pattern_all = {pattern_bytes_high, pattern_bytes_low};
      for (int i = 0; i < MAX_PATTERN; i++) begin
         pos_diff           = LEN_WIDTH'(i) - base;
         active[i]          = LEN_WIDTH'(i) >= base;
         pattern_aligned[i] = pattern_all[8*pos_diff[POS_WIDTH-1:0] +: 8];
      end
   end

   // Every pair in use must agree on equal versus unequal.
   always_comb begin
      mismatch = 1'b0;
      for (int a = 0; a < MAX_PATTERN - 1; a++) begin
         for (int b = a + 1; b < MAX_PATTERN; b++) begin
            if (active[a] &&
                ((window[a] == window[b]) != (pattern_aligned[a] == pattern_aligned[b]))) begin
               mismatch = 1'b1;
            end
         end
      end
   end

   // A match needs a usable length and a full window.
   always_comb begin
      window_full   = bytes_seen >= OFFSET_WIDTH'(len_eff);
      result.hit    = (len_eff >= MIN_PATTERN) && window_full && !mismatch;
      result.offset = bytes_seen - OFFSET_WIDTH'(len_eff);
   end

endmodule

// ===== src/equality_pattern_byte_search.sv =====
// Equality-pattern byte search: top level with configuration and handshakes.
//
// The block searches a byte stream for windows whose pattern of equal and
// unequal bytes matches the configured pattern bytes. Bytes enter on the req_
// channel (req_data_byte, with req_restart marking the first byte of a new
// stream); a matching window yields one transaction on the rsp_ channel that
// carries the stream offset of the window's first byte. Bytes that complete
// no match produce no transaction.
// A taken byte is held in the window register; its result is then held
// in the result register. One byte is taken every cycle while req_stall
// is low; all byte pairs compare in parallel in a single stage between them.
// When the receiver stalls, the result register holds its transaction and
// one more byte can be taken into the window; after that req_stall rises
// until the result is taken. Reset clears the window, the stream count and
// both channels, and sets pattern length 2 with all pattern bytes zero.
// The user must write the csr_ registers (pattern length, pattern bytes 0 to 7,
// pattern bytes 8 to 15) only with no transaction in flight (not enforced).
module equality_pattern_byte_search (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_data_byte,
   input  logic                               req_restart,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [eqps_pkg::OFFSET_WIDTH-1:0]  rsp_match_offset,
   input  logic                               csr_write_enable,
   input  logic [eqps_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [eqps_pkg::CSR_WIDTH-1:0]     csr_write_data
);
   import eqps_pkg::*;

   logic [LEN_WIDTH-1:0]    length_ff, length_in;
   logic [CSR_WIDTH-1:0]    low_ff, low_in;
   logic [CSR_WIDTH-1:0]    high_ff, high_in;
   logic                    eval_valid_ff, eval_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_WIDTH-1:0] offset_ff, offset_in;

   logic                    accept;
   logic                    slot_free;
   logic                    advance;
   window_type              window;
   logic [OFFSET_WIDTH-1:0] bytes_seen;
   match_type               result;

   // Configuration register writes.
   always_comb begin
      length_in = length_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PATTERN_LENGTH: length_in = csr_write_data[LEN_WIDTH-1:0];
            CSR_PATTERN_LOW:    low_in    = csr_write_data;
            CSR_PATTERN_HIGH:   high_in   = csr_write_data;
            default:            ;
         endcase
      end
   end

   // Handshake control: the window holds one byte awaiting evaluation.
   always_comb begin
      slot_free = !rsp_valid_ff || !rsp_stall;
      advance   = eval_valid_ff && slot_free;
      req_stall = eval_valid_ff && !slot_free;
      accept    = req_valid && !req_stall;
   end

   always_comb begin
      eval_valid_in = accept ? 1'b1 : (advance ? 1'b0 : eval_valid_ff);
      rsp_valid_in  = rsp_valid_ff;
      offset_in     = offset_ff;
      if (advance) begin
         rsp_valid_in = result.hit;
         offset_in    = result.offset;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff     <= PATTERN_LENGTH_RESET;
         low_ff        <= '0;
         high_ff       <= '0;
         eval_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         length_ff     <= length_in;
         low_ff        <= low_in;
         high_ff       <= high_in;
         eval_valid_ff <= eval_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
   end

   eqps_window u_window (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .restart    (req_restart),
      .window     (window),
      .bytes_seen (bytes_seen)
   );

   eqps_match u_match (
      .pattern_length     (length_ff),
      .pattern_bytes_low  (low_ff),
      .pattern_bytes_high (high_ff),
      .window             (window),
      .bytes_seen         (bytes_seen),
      .result             (result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_match_offset = offset_ff;

endmodule

// ===== test/equality_pattern_byte_search_tb.sv =====
// Self-checking testbench for the equality-pattern byte search block.
module equality_pattern_byte_search_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import eqps_pkg::*;

   localparam int ITEM_TARGET = 1450;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 4;

   typedef struct packed {
      logic [7:0] data;
      logic       restart;
   } stream_byte_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [7:0]               req_data_byte = 8'h00;
   logic                     req_restart = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [OFFSET_WIDTH-1:0]  rsp_match_offset;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_IDX_WIDTH-1:0] csr_index = CSR_PATTERN_LENGTH;
   logic [CSR_WIDTH-1:0]     csr_write_data = '0;

   // Configuration as last written, shared by stimulus and prediction.
   logic [LEN_WIDTH-1:0]        cfg_length = PATTERN_LENGTH_RESET;
   logic [8*MAX_PATTERN-1:0]    cfg_pattern = '0;

   // Predicted state of the search.
   window_type                  search_window = '0;
   logic [OFFSET_WIDTH-1:0]     stream_count = '0;
   logic [OFFSET_WIDTH-1:0]     expected_offsets[$];

   stream_byte_type             pending_bytes[$];
   stream_byte_type             next_byte;
   logic [OFFSET_WIDTH-1:0]     wanted_offset;
   logic [LEN_WIDTH-1:0]        forced_lengths [6] = '{5'd16, 5'd2, 5'd31, 5'd1, 5'd17, 5'd0};

   int  bytes_outstanding = 0;
   int  bytes_pushed = 0;
   int  restart_count = 0;
   int  config_count = 0;
   int  matches_checked = 0;
   int  error_count = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  cycle_count = 0;
   bit  calm_tail = 1'b0;

   equality_pattern_byte_search dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_match_offset (rsp_match_offset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Prints one line per error and counts it.
   task flag_error(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // Lengths above the window size behave as the full window.
   function automatic int effective_length();
      return (cfg_length > MAX_PATTERN_LEN) ? MAX_PATTERN : int'(cfg_length);
   endfunction

   // Shifts one accepted byte into the window and predicts a match.
   task advance_stream(input logic [7:0] data, input logic restart);
      int   eff_len;
      int   base;
      logic hit;
      if (restart) begin
         search_window = '0;
         stream_count = '0;
         restart_count++;
      end
      search_window = {data, search_window[MAX_PATTERN-1:1]};
      if (stream_count != '1) begin
         stream_count++;
      end
      eff_len = effective_length();
      if (eff_len >= 2 && stream_count >= eff_len) begin
         hit = 1'b1;
         base = MAX_PATTERN - eff_len;
         for (int j = 0; j < eff_len - 1; j++) begin
            for (int k = j + 1; k < eff_len; k++) begin
               if ((cfg_pattern[j*8 +: 8] == cfg_pattern[k*8 +: 8]) !=
                   (search_window[base+j] == search_window[base+k])) begin
                  hit = 1'b0;
               end
            end
         end
         if (hit) begin
            expected_offsets.push_back(stream_count - OFFSET_WIDTH'(eff_len));
         end
      end
   endtask

   task push_byte(input logic [7:0] data, input logic restart);
      pending_bytes.push_back('{data: data, restart: restart});
      bytes_outstanding++;
      bytes_pushed++;
   endtask

   // Byte values biased toward the extremes and toward repeats.
   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 3))
         0: begin
            return 8'h00;
         end
         1: begin
            return 8'hFF;
         end
         2: begin
            return 8'($urandom_range(0, 3));
         end
         default: begin
            return 8'($urandom_range(0, 255));
         end
      endcase
   endfunction

   // Sends a window whose equality pattern follows the configured bytes,
   // optionally with one byte overwritten so that it usually fails.
   task plant_window(input logic restart, input bit broken);
      logic [7:0] window_value [MAX_PATTERN];
      logic [7:0] candidate;
      int         eff_len;
      bit         found;
      bit         fresh;
      eff_len = effective_length();
      for (int j = 0; j < eff_len; j++) begin
         found = 1'b0;
         for (int i = 0; i < j; i++) begin
            if (!found && cfg_pattern[i*8 +: 8] == cfg_pattern[j*8 +: 8]) begin
               window_value[j] = window_value[i];
               found = 1'b1;
            end
         end
         if (!found) begin
            do begin
               candidate = noise_byte();
               fresh = 1'b1;
               for (int i = 0; i < j; i++) begin
                  if (window_value[i] == candidate) begin
                     fresh = 1'b0;
                  end
               end
            end while (!fresh);
            window_value[j] = candidate;
         end
      end
      if (broken) begin
         window_value[$urandom_range(0, eff_len - 1)] = 8'($urandom_range(0, 255));
      end
      for (int j = 0; j < eff_len; j++) begin
         push_byte(window_value[j], (j == 0) ? restart : 1'b0);
      end
   endtask

   // Holds off until every byte is taken and every match has come back.
   task wait_drained();
      do begin
         @(posedge clock);
      end while (bytes_outstanding != 0 || expected_offsets.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_reg(input logic [CSR_IDX_WIDTH-1:0] index, input logic [CSR_WIDTH-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      case (index)
         CSR_PATTERN_LENGTH: begin
            cfg_length = data[LEN_WIDTH-1:0];
         end
         CSR_PATTERN_LOW: begin
            cfg_pattern[63:0] = data;
         end
         CSR_PATTERN_HIGH: begin
            cfg_pattern[127:64] = data;
         end
         default: begin
         end
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task apply_config(input logic [LEN_WIDTH-1:0] len, input logic [8*MAX_PATTERN-1:0] pattern);
      wait_drained();
      write_reg(CSR_PATTERN_LENGTH, CSR_WIDTH'(len));
      write_reg(CSR_PATTERN_LOW, pattern[63:0]);
      write_reg(CSR_PATTERN_HIGH, pattern[127:64]);
      config_count++;
   endtask

   // Draws a pattern from a palette of 1 to 16 byte values, or all ones on request.
   task pick_config(input logic [LEN_WIDTH-1:0] len, input bit all_ones);
      logic [7:0]               palette [MAX_PATTERN];
      logic [8*MAX_PATTERN-1:0] pattern;
      int                       colors;
      colors = $urandom_range(1, MAX_PATTERN);
      for (int i = 0; i < MAX_PATTERN; i++) begin
         palette[i] = 8'($urandom_range(0, 255));
      end
      for (int i = 0; i < MAX_PATTERN; i++) begin
         pattern[i*8 +: 8] = palette[$urandom_range(0, colors - 1)];
      end
      if (all_ones) begin
         pattern = '1;
      end
      apply_config(len, pattern);
   endtask

   // Driver: predicts each accepted transaction and feeds the next byte.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_stream(req_data_byte, req_restart);
            bytes_outstanding--;
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0 && !calm_tail &&
                         $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(0, 6);
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               next_byte = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= next_byte.data;
               req_restart <= next_byte.restart;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each match transaction and stalls in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_offsets.size() == 0) begin
               flag_error($sformatf("match at offset %0d with none expected", rsp_match_offset));
            end else begin
               wanted_offset = expected_offsets.pop_front();
               matches_checked++;
               if (rsp_match_offset !== wanted_offset) begin
                  flag_error($sformatf("match_offset %0d, expected %0d",
                                       rsp_match_offset, wanted_offset));
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 6);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      logic [LEN_WIDTH-1:0] len;
      logic                 restart;
      int                   phase;
      int                   phase_end;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset values: length 2, zero pattern, so two equal bytes match.
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0);
      // A restart clears the window, so the restart byte cannot match the
      // byte before it; the equal byte after it matches at offset 0.
      push_byte(8'h7E, 1'b1);
      push_byte(8'h7E, 1'b0);

      // Three bytes: first two equal, third different.
      apply_config(5'd3, 128'hFF_0000);
      push_byte(8'h41, 1'b1);
      push_byte(8'h41, 1'b0);
      push_byte(8'h42, 1'b0);
      push_byte(8'h42, 1'b0);
      push_byte(8'h43, 1'b0);

      // Short patterns never match, even on equal bytes.
      apply_config(5'd0, '0);
      push_byte(8'h10, 1'b1);
      push_byte(8'h10, 1'b0);
      push_byte(8'h10, 1'b0);
      apply_config(5'd1, '0);
      push_byte(8'h10, 1'b0);
      push_byte(8'h10, 1'b0);

      // Random phases, each under a new setting; first ones cover the extremes.
      phase = 0;
      while (bytes_pushed < ITEM_TARGET) begin
         if (phase < 6) begin
            len = forced_lengths[phase];
         end else if ($urandom_range(0, 7) == 0) begin
            len = LEN_WIDTH'($urandom_range(0, 31));
         end else begin
            len = LEN_WIDTH'($urandom_range(2, MAX_PATTERN));
         end
         pick_config(len, phase == 2);
         if (bytes_pushed >= ITEM_TARGET - 200) begin
            calm_tail = 1'b1;
         end
         phase_end = bytes_pushed + ((effective_length() < 2) ? 40 : $urandom_range(80, 140));
         while (bytes_pushed < phase_end) begin
            restart = ($urandom_range(0, 24) == 0);
            if (effective_length() >= 2 && $urandom_range(0, 9) < 6) begin
               plant_window(restart, $urandom_range(0, 6) == 0);
            end else begin
               repeat ($urandom_range(1, 6)) begin
                  push_byte(noise_byte(), restart);
                  restart = 1'b0;
               end
            end
         end
         phase++;
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Searched %0d bytes with %0d restarts under %0d pattern settings.",
               bytes_pushed, restart_count, config_count);
      $display("Checked %0d match offsets; %0d errors.", matches_checked, error_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/eqps_pkg.sv
src/eqps_window.sv
src/eqps_match.sv
src/equality_pattern_byte_search.sv
test/equality_pattern_byte_search_tb.sv
